// ----- hdl/bpc_pkg.sv -----
// Shared types, constants and helpers for the pressure and temperature compensation block.
package bpc_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned RawW = 19;
	localparam int unsigned CntW = 6;

	// Register byte addresses.
	localparam logic [4:0] RegAc1Ac2 = 5'd0;
	localparam logic [4:0] RegAc3Ac4 = 5'd4;
	localparam logic [4:0] RegAc5Ac6 = 5'd8;
	localparam logic [4:0] RegB1B2 = 5'd12;
	localparam logic [4:0] RegMcMd = 5'd16;
	localparam logic [4:0] RegOss = 5'd20;

	// Datapath commands issued by the controller.
	localparam logic [4:0] CmdNone = 5'd0;
	localparam logic [4:0] CmdT1 = 5'd1;
	localparam logic [4:0] CmdT2 = 5'd2;
	localparam logic [4:0] CmdTDivInit = 5'd3;
	localparam logic [4:0] CmdTFin = 5'd4;
	localparam logic [4:0] CmdP1 = 5'd5;
	localparam logic [4:0] CmdP2 = 5'd6;
	localparam logic [4:0] CmdP3 = 5'd7;
	localparam logic [4:0] CmdP4 = 5'd8;
	localparam logic [4:0] CmdP5 = 5'd9;
	localparam logic [4:0] CmdP6 = 5'd10;
	localparam logic [4:0] CmdP7 = 5'd11;
	localparam logic [4:0] CmdPDivInit = 5'd12;
	localparam logic [4:0] CmdPF1 = 5'd13;
	localparam logic [4:0] CmdPF2 = 5'd14;
	localparam logic [4:0] CmdPF3 = 5'd15;
	localparam logic [4:0] CmdPFin = 5'd16;
	localparam logic [4:0] CmdDivStep = 5'd17;
	localparam logic [4:0] CmdZero = 5'd18;

	typedef struct packed {
		logic [4:0] cmd;
	} bpc_cmd_t;

	typedef struct packed {
		logic t_den_zero;
		logic p_den_zero;
	} bpc_stat_t;

	// Arithmetic right shift of a 32-bit word.
	function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
		asr = 32'($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] h);
		sx16 = {{16{h[15]}}, h};
	endfunction

endpackage

// ----- hdl/bpc_ctrl.sv -----
// Controller state machine that sequences the compensation datapath.
module bpc_ctrl import bpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_op,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input bpc_stat_t stat,
	output bpc_cmd_t cmd,
	output logic load_in
);

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StTemp = 3'd1;
	localparam logic [2:0] StPres = 3'd2;
	localparam logic [2:0] StDiv = 3'd3;
	localparam logic [2:0] StFin = 3'd4;
	localparam logic [2:0] StOut = 3'd5;

	logic [2:0] state_q;
	logic [3:0] step_q;
	logic [CntW-1:0] cnt_q;
	logic op_q;

	assign in_stall = (state_q != StIdle);
	assign load_in = in_valid && (state_q == StIdle);
	assign out_valid = (state_q == StOut);

	// Command decode per state and step.
	always_comb begin
		cmd.cmd = CmdNone;
		unique case (state_q)
			StTemp: begin
				if (step_q == 4'd0) cmd.cmd = CmdT1;
				else if (step_q == 4'd1) cmd.cmd = CmdT2;
				else cmd.cmd = stat.t_den_zero ? CmdZero : CmdTDivInit;
			end
			StPres: begin
				unique case (step_q)
					4'd0: cmd.cmd = CmdP1;
					4'd1: cmd.cmd = CmdP2;
					4'd2: cmd.cmd = CmdP3;
					4'd3: cmd.cmd = CmdP4;
					4'd4: cmd.cmd = CmdP5;
					4'd5: cmd.cmd = CmdP6;
					4'd6: cmd.cmd = CmdP7;
					default: cmd.cmd = stat.p_den_zero ? CmdZero : CmdPDivInit;
				endcase
			end
			StDiv: cmd.cmd = CmdDivStep;
			StFin: begin
				if (!op_q) cmd.cmd = CmdTFin;
				else if (step_q == 4'd0) cmd.cmd = CmdPF1;
				else if (step_q == 4'd1) cmd.cmd = CmdPF2;
				else if (step_q == 4'd2) cmd.cmd = CmdPF3;
				else cmd.cmd = CmdPFin;
			end
			default: cmd.cmd = CmdNone;
		endcase
	end

	// Sequencing of states, steps and the divider count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			step_q <= '0;
			cnt_q <= '0;
			op_q <= 1'b0;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (in_valid) begin
						op_q <= in_op;
						step_q <= '0;
						state_q <= in_op ? StPres : StTemp;
					end
				end
				StTemp: begin
					if (step_q == 4'd2) begin
						step_q <= '0;
						cnt_q <= '0;
						state_q <= stat.t_den_zero ? StOut : StDiv;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				StPres: begin
					if (step_q == 4'd7) begin
						step_q <= '0;
						cnt_q <= '0;
						state_q <= stat.p_den_zero ? StOut : StDiv;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				StDiv: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(DataW - 1)) state_q <= StFin;
				end
				StFin: begin
					if (!op_q || step_q == 4'd3) begin
						state_q <= StOut;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				StOut: begin
					if (!out_stall) state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

endmodule

// ----- hdl/bpc_datapath.sv -----
// Datapath: calibration arithmetic, shared multiplier and a restoring divider.
module bpc_datapath import bpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input bpc_cmd_t cmd,
	input logic load_in,
	input logic in_op,
	input logic [RawW-1:0] in_raw,
	input logic [31:0] cal_ac1_ac2,
	input logic [31:0] cal_ac3_ac4,
	input logic [31:0] cal_ac5_ac6,
	input logic [31:0] cal_b1_b2,
	input logic [31:0] cal_mc_md,
	input logic [1:0] oss,
	output bpc_stat_t stat,
	output logic res_kind,
	output logic [31:0] res_value,
	output logic res_status
);

	logic [RawW-1:0] raw_q;
	logic [31:0] b5_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] quo_q, rem_q, dvd_q, dvs_q;
	logic neg_q, pshift_q;
	logic [31:0] value_q;
	logic status_q;
	logic kind_q;

	logic [31:0] b6, ac1, ac2, ac3, ac4, b1, b2, mcs, md;
	logic [31:0] m_a, m_b, m_p;
	logic [32:0] rem_sh;
	logic [31:0] dvs_abs, num_abs, x1t, tden;
	logic [31:0] p_fix;

	assign b6 = b5_q - 32'd4000;
	assign ac1 = sx16(cal_ac1_ac2[31:16]);
	assign ac2 = sx16(cal_ac1_ac2[15:0]);
	assign ac3 = sx16(cal_ac3_ac4[31:16]);
	assign ac4 = {16'd0, cal_ac3_ac4[15:0]};
	assign b1 = sx16(cal_b1_b2[31:16]);
	assign b2 = sx16(cal_b1_b2[15:0]);
	assign mcs = sx16(cal_mc_md[31:16]) << 11;
	assign md = sx16(cal_mc_md[15:0]);
	assign x1t = a_q;
	assign tden = x1t + md;

	// Pressure quotient, doubled when the dividend was too large to pre-shift.
	assign p_fix = pshift_q ? (quo_q << 1) : quo_q;

	// One shared 32 by 32 multiplier, low word kept.
	always_comb begin
		m_a = '0;
		m_b = '0;
		case (cmd.cmd)
			CmdT1: begin
				m_a = {13'd0, raw_q} - {16'd0, cal_ac5_ac6[15:0]};
				m_b = {16'd0, cal_ac5_ac6[31:16]};
			end
			CmdP1: begin m_a = b6; m_b = b6; end
			CmdP2: begin m_a = b2; m_b = a_q; end
			CmdP3: begin m_a = ac2; m_b = b6; end
			CmdP4: begin m_a = ac3; m_b = b6; end
			CmdP5: begin m_a = b1; m_b = a_q; end
			CmdP6: begin m_a = ac4; m_b = asr(c_q + d_q + 32'd2, 2) + 32'd32768; end
			CmdP7: begin m_a = {13'd0, raw_q} - e_q; m_b = 32'd50000 >> oss; end
			CmdPF1: begin m_a = 32'd7357; m_b = p_fix; end
			CmdPF2: begin m_a = asr(quo_q, 8); m_b = asr(quo_q, 8); end
			CmdPF3: begin m_a = a_q; m_b = 32'd3038; end
			default: begin m_a = '0; m_b = '0; end
		endcase
		m_p = m_a * m_b;
	end

	assign dvs_abs = dvs_q;
	assign rem_sh = {rem_q, dvd_q[31]};
	assign num_abs = mcs[31] ? (32'd0 - mcs) : mcs;

	assign stat.t_den_zero = (tden == 32'd0);
	assign stat.p_den_zero = (b_q == 32'd0);

	// Step registers of the sequence.
	always_ff @(posedge clk) begin
		if (load_in) begin
			raw_q <= in_raw;
			kind_q <= in_op;
		end
		case (cmd.cmd)
			CmdT1: a_q <= asr(m_p, 15);
			CmdTDivInit: begin
				dvd_q <= num_abs;
				dvs_q <= tden[31] ? (32'd0 - tden) : tden;
				neg_q <= mcs[31] ^ tden[31];
				rem_q <= '0;
				quo_q <= '0;
			end
			CmdP1: a_q <= asr(m_p, 12);
			CmdP2: c_q <= asr(m_p, 11);
			CmdP3: begin
				e_q <= asr((((ac1 << 2) + c_q + asr(m_p, 11)) << oss) + 32'd2, 2);
			end
			CmdP4: c_q <= asr(m_p, 13);
			CmdP5: d_q <= asr(m_p, 16);
			CmdP6: b_q <= m_p >> 15;
			CmdP7: d_q <= m_p;
			CmdPDivInit: begin
				pshift_q <= d_q[31];
				dvd_q <= d_q[31] ? d_q : (d_q << 1);
				dvs_q <= b_q;
				neg_q <= 1'b0;
				rem_q <= '0;
				quo_q <= '0;
			end
			CmdDivStep: begin
				dvd_q <= dvd_q << 1;
				if (rem_sh >= {1'b0, dvs_abs}) begin
					rem_q <= 32'(rem_sh - {1'b0, dvs_abs});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			CmdPF1: begin
				quo_q <= p_fix;
				c_q <= asr(32'd0 - m_p, 16);
			end
			CmdPF2: a_q <= m_p;
			CmdPF3: a_q <= asr(m_p, 16);
			default: ;
		endcase
		if (cmd.cmd == CmdTFin || cmd.cmd == CmdPFin || cmd.cmd == CmdZero) begin
			status_q <= (cmd.cmd == CmdZero);
		end
		if (cmd.cmd == CmdZero) value_q <= '0;
		if (cmd.cmd == CmdTFin) value_q <= asr(x1t + (neg_q ? 32'd0 - quo_q : quo_q) + 32'd8, 4);
		if (cmd.cmd == CmdPFin) value_q <= quo_q + asr(a_q + c_q + 32'd3791, 4);
	end

	// Stored temperature term.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b5_q <= '0;
		end else if (cmd.cmd == CmdTFin) begin
			b5_q <= x1t + (neg_q ? 32'd0 - quo_q : quo_q);
		end
	end

	assign res_kind = kind_q;
	assign res_value = value_q;
	assign res_status = status_q;

endmodule

// ----- hdl/barometric_pressure_temp_compensation.sv -----
// Top level of the barometric pressure and temperature compensation block.
// Usage:
// The input channel (in_valid, in_stall, op, raw_sample) takes one raw sample per
// transaction; op selects temperature or pressure. The output channel (out_valid,
// out_stall, kind, value, status) returns exactly one result per input transaction.
// Calibration words and the oversampling setting must be written over the APB port
// only while the block is idle; the block itself does not enforce this.
// A result is computed through the shared multiplier steps and the restoring
// divider; when a divisor is zero the divider is skipped.
// One sample is processed at a time, so a new sample is accepted only after the
// previous result has been taken.
// Reset clears the APB registers, the stored temperature term and the controller.
// While the receiver stalls, the result holds and no new sample is accepted.
module barometric_pressure_temp_compensation import bpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic op,
	input logic [RawW-1:0] raw_sample,
	output logic out_valid,
	input logic out_stall,
	output logic kind,
	output logic signed [31:0] value,
	output logic status
);

	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0] oss_q;
	bpc_cmd_t cmd;
	bpc_stat_t stat;
	logic load_in;
	logic [31:0] res_value;

	assign pready = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0; ac34_q <= '0; ac56_q <= '0;
			b12_q <= '0; mcmd_q <= '0; oss_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				RegAc1Ac2: ac12_q <= pwdata;
				RegAc3Ac4: ac34_q <= pwdata;
				RegAc5Ac6: ac56_q <= pwdata;
				RegB1B2: b12_q <= pwdata;
				RegMcMd: mcmd_q <= pwdata;
				RegOss: oss_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		unique case (paddr)
			RegAc1Ac2: prdata = ac12_q;
			RegAc3Ac4: prdata = ac34_q;
			RegAc5Ac6: prdata = ac56_q;
			RegB1B2: prdata = b12_q;
			RegMcMd: prdata = mcmd_q;
			RegOss: prdata = {30'd0, oss_q};
			default: prdata = '0;
		endcase
	end

	bpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_op(op),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd), .load_in(load_in)
	);

	bpc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .load_in(load_in), .in_op(op),
		.in_raw(raw_sample), .cal_ac1_ac2(ac12_q), .cal_ac3_ac4(ac34_q),
		.cal_ac5_ac6(ac56_q), .cal_b1_b2(b12_q), .cal_mc_md(mcmd_q), .oss(oss_q),
		.stat(stat), .res_kind(kind), .res_value(res_value), .res_status(status)
	);

	assign value = $signed(res_value);

endmodule
